@@ src/urp_pkg.sv @@
// Shared types and constants for the UDP tracker response parser.
package urp_pkg;

    // expected response kinds (configuration codes)
    localparam logic [1:0] KIND_CONNECT  = 2'd0;
    localparam logic [1:0] KIND_ANNOUNCE = 2'd1;
    localparam logic [1:0] KIND_SCRAPE   = 2'd2;

    // record kinds on the result channel
    localparam logic [2:0] REC_CONN_ID   = 3'd0;
    localparam logic [2:0] REC_ANNOUNCE  = 3'd1;
    localparam logic [2:0] REC_PEER      = 3'd2;
    localparam logic [2:0] REC_SCRAPE    = 3'd3;
    localparam logic [2:0] REC_DONE_OK   = 3'd4;
    localparam logic [2:0] REC_DONE_FAIL = 3'd5;

    // register indexes on the configuration port
    localparam logic REG_EXPECTED_KIND = 1'b0;
    localparam logic REG_HASH_COUNT    = 1'b1;

    localparam logic [31:0] ACTION_ERROR  = 32'd3;
    localparam logic [6:0]  MAX_HASHES    = 7'd64;
    localparam logic [15:0] PEER_PORT_MAX = 16'd65000;
    localparam logic [15:0] LEN_CONNECT   = 16'd16;
    localparam logic [15:0] LEN_ANNOUNCE  = 16'd20;
    localparam logic [15:0] LEN_SCRAPE_HD = 16'd8;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic [63:0] field_a;
        logic [31:0] field_b;
        logic [31:0] field_c;
        logic [13:0] entry_index;
        logic        end_of_packet;
    } t_out_item;

    typedef struct packed {
        logic [1:0] expected_kind;
        logic [6:0] scrape_hash_count;
    } t_cfg;

    // results produced by one byte: at most one record, then possibly a status
    typedef struct packed {
        logic [1:0] count;
        t_out_item  first;
        t_out_item  second;
    } t_push;

    typedef struct packed {
        logic [2:0] count;
        logic       room;
    } t_q_status;

endpackage

@@ src/udp_tracker_response_parser.sv @@
// Top level of the UDP tracker response parser.
//
//  channel   direction  handshake                payload
//  in        input      i_in_valid / o_in_ready  i_in_data  (t_in_item)
//  out       output     o_out_valid / i_out_ready o_out_data (t_out_item)
//  cfg       input      psel/penable/pwrite       paddr, pwdata, prdata
//
// One byte per cycle while input ready is high. A byte is parsed in the cycle it
// transfers; its records enter a four-entry queue, which drives the output.
// Input ready drops only while the queue holds more than two records, so a
// stalled output pauses the input once more than two records wait.
// Reset clears packet state and the queue; registers go to connect, one hash.
module udp_tracker_response_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  urp_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output urp_pkg::t_out_item o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import urp_pkg::*;

    t_cfg      w_cfg;
    t_push     w_push;
    t_q_status w_qs;
    logic      w_fire;

    assign o_in_ready = w_qs.room;
    assign w_fire     = i_in_valid && o_in_ready;

    urp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    urp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (i_in_data),
        .i_cfg   (w_cfg),
        .o_push  (w_push)
    );

    urp_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_item   (o_out_data),
        .o_status (w_qs)
    );

    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qs.count <= 3'd4)
        else $error("result queue overflow");

    a_status_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_in_data.last_byte) |=> o_out_valid)
        else $error("status record missing after last byte");

    a_eop_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.end_of_packet) |->
        (o_out_data.record_kind == REC_DONE_OK || o_out_data.record_kind == REC_DONE_FAIL))
        else $error("end of packet on a non-status record");

    a_two_needs_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.count == 2'd2) |-> (w_fire && i_in_data.last_byte))
        else $error("double push without last byte");

endmodule

@@ src/urp_cfg.sv @@
// APB configuration registers: expected kind and scrape hash count.
module urp_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output urp_pkg::t_cfg o_cfg
);
    import urp_pkg::*;

    logic [1:0] r_kind, n_kind;
    logic [6:0] r_hcnt, n_hcnt;
    logic       w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_comb begin
        n_kind = r_kind;
        n_hcnt = r_hcnt;
        if (w_wr) begin
            unique case (paddr[2])
                REG_EXPECTED_KIND: n_kind = pwdata[1:0];
                REG_HASH_COUNT:    n_hcnt = pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_CONNECT;
            r_hcnt <= 7'd1;
        end else begin
            r_kind <= n_kind;
            r_hcnt <= n_hcnt;
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_EXPECTED_KIND: prdata = {30'd0, r_kind};
            REG_HASH_COUNT:    prdata = {25'd0, r_hcnt};
            default:           prdata = 32'd0;
        endcase
    end

    assign o_cfg.expected_kind     = r_kind;
    assign o_cfg.scrape_hash_count = r_hcnt;

endmodule

@@ src/urp_parser.sv @@
// Byte parser: packet state, field accumulators and record generation.
module urp_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  urp_pkg::t_in_item i_item,
    input  urp_pkg::t_cfg     i_cfg,
    output urp_pkg::t_push    o_push
);
    import urp_pkg::*;

    logic [15:0] r_count, n_count;
    logic [31:0] r_action, n_action;
    logic [63:0] r_acc_a, n_acc_a;
    logic [31:0] r_acc_b, n_acc_b;
    logic [31:0] r_acc_c, n_acc_c;
    logic        r_bad, n_bad;
    logic [13:0] r_entry, n_entry;
    // offset within a 6-byte peer, and position within scrape triples
    logic [2:0]  r_off6, n_off6;
    logic [3:0]  r_off12, n_off12;
    logic [12:0] r_idx12, n_idx12;

    logic [7:0]  w_b;
    logic [1:0]  w_kind;
    logic [6:0]  w_hc;
    logic [15:0] w_need;
    logic        w_ok;
    logic [15:0] w_port;

    assign w_b    = i_item.data_byte;
    assign w_kind = i_cfg.expected_kind;
    assign w_hc   = (i_cfg.scrape_hash_count > MAX_HASHES) ? MAX_HASHES
                                                           : i_cfg.scrape_hash_count;

    always_comb begin
        n_count = r_count;
        n_action = r_action;
        n_acc_a = r_acc_a;
        n_acc_b = r_acc_b;
        n_acc_c = r_acc_c;
        n_bad = r_bad;
        n_entry = r_entry;
        n_off6 = r_off6;
        n_off12 = r_off12;
        n_idx12 = r_idx12;
        o_push = '0;
        w_need = LEN_CONNECT;
        w_ok = 1'b0;
        w_port = 16'd0;

        if (i_fire && r_count != COUNT_MAX) begin
            n_count = r_count + 16'd1;
            if (r_count < 16'd4) begin
                n_action = {r_action[23:0], w_b};
                if (r_count == 16'd3 && (w_kind > KIND_SCRAPE || n_action == ACTION_ERROR ||
                                         n_action != {30'd0, w_kind}))
                    n_bad = 1'b1;
            end else if (r_count >= 16'd8 && !r_bad) begin
                case (w_kind)
                    KIND_CONNECT: begin
                        if (r_count < 16'd16) begin
                            n_acc_a = {r_acc_a[55:0], w_b};
                            if (r_count == 16'd15) begin
                                o_push.count = 2'd1;
                                o_push.first.record_kind = REC_CONN_ID;
                                o_push.first.field_a = n_acc_a;
                            end
                        end
                    end
                    KIND_ANNOUNCE: begin
                        if (r_count < 16'd12) begin
                            n_acc_a = {r_acc_a[55:0], w_b};
                        end else if (r_count < 16'd16) begin
                            n_acc_b = {r_acc_b[23:0], w_b};
                        end else if (r_count < 16'd20) begin
                            n_acc_c = {r_acc_c[23:0], w_b};
                            if (r_count == 16'd19) begin
                                o_push.count = 2'd1;
                                o_push.first.record_kind = REC_ANNOUNCE;
                                o_push.first.field_a = {32'd0, n_acc_a[31:0]};
                                o_push.first.field_b = n_acc_b;
                                o_push.first.field_c = n_acc_c;
                            end
                        end else begin
                            if (r_off6 < 3'd4)
                                n_acc_a = {r_acc_a[55:0], w_b};
                            else
                                n_acc_b = {r_acc_b[23:0], w_b};
                            if (r_off6 == 3'd5) begin
                                w_port = n_acc_b[15:0];
                                // zero address and out-of-range ports burn a slot
                                if (n_acc_a[31:0] != 32'd0 && w_port != 16'd0 &&
                                    w_port <= PEER_PORT_MAX) begin
                                    o_push.count = 2'd1;
                                    o_push.first.record_kind = REC_PEER;
                                    o_push.first.field_a = {32'd0, n_acc_a[31:0]};
                                    o_push.first.field_b = {16'd0, w_port};
                                    o_push.first.entry_index = r_entry;
                                end
                                n_entry = r_entry + 14'd1;
                            end
                        end
                    end
                    KIND_SCRAPE: begin
                        if (r_idx12 < {6'd0, w_hc}) begin
                            if (r_off12 < 4'd4)
                                n_acc_a = {r_acc_a[55:0], w_b};
                            else if (r_off12 < 4'd8)
                                n_acc_b = {r_acc_b[23:0], w_b};
                            else
                                n_acc_c = {r_acc_c[23:0], w_b};
                            if (r_off12 == 4'd11) begin
                                o_push.count = 2'd1;
                                o_push.first.record_kind = REC_SCRAPE;
                                o_push.first.field_a = {32'd0, n_acc_a[31:0]};
                                o_push.first.field_b = n_acc_b;
                                o_push.first.field_c = n_acc_c;
                                o_push.first.entry_index = {1'b0, r_idx12};
                                n_entry = {1'b0, r_idx12} + 14'd1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            // position trackers run regardless of kind so a mid-packet write works
            if (r_count >= 16'd8) begin
                if (r_off12 == 4'd11) begin
                    n_off12 = 4'd0;
                    n_idx12 = r_idx12 + 13'd1;
                end else begin
                    n_off12 = r_off12 + 4'd1;
                end
            end
            if (r_count >= 16'd20)
                n_off6 = (r_off6 == 3'd5) ? 3'd0 : r_off6 + 3'd1;
        end

        if (i_fire && i_item.last_byte) begin
            case (w_kind)
                KIND_CONNECT:  w_need = LEN_CONNECT;
                KIND_ANNOUNCE: w_need = LEN_ANNOUNCE;
                default:       w_need = LEN_SCRAPE_HD + ({9'd0, w_hc} << 3)
                                        + ({9'd0, w_hc} << 2);
            endcase
            w_ok = !n_bad && w_kind <= KIND_SCRAPE && n_count >= w_need;
            if (o_push.count == 2'd1) begin
                o_push.count = 2'd2;
                o_push.second.record_kind = w_ok ? REC_DONE_OK : REC_DONE_FAIL;
                o_push.second.end_of_packet = 1'b1;
            end else begin
                o_push.count = 2'd1;
                o_push.first.record_kind = w_ok ? REC_DONE_OK : REC_DONE_FAIL;
                o_push.first.end_of_packet = 1'b1;
            end
            n_count = 16'd0;
            n_action = 32'd0;
            n_acc_a = 64'd0;
            n_acc_b = 32'd0;
            n_acc_c = 32'd0;
            n_bad = 1'b0;
            n_entry = 14'd0;
            n_off6 = 3'd0;
            n_off12 = 4'd0;
            n_idx12 = 13'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 16'd0;
            r_action <= 32'd0;
            r_acc_a <= 64'd0;
            r_acc_b <= 32'd0;
            r_acc_c <= 32'd0;
            r_bad <= 1'b0;
            r_entry <= 14'd0;
            r_off6 <= 3'd0;
            r_off12 <= 4'd0;
            r_idx12 <= 13'd0;
        end else begin
            r_count <= n_count;
            r_action <= n_action;
            r_acc_a <= n_acc_a;
            r_acc_b <= n_acc_b;
            r_acc_c <= n_acc_c;
            r_bad <= n_bad;
            r_entry <= n_entry;
            r_off6 <= n_off6;
            r_off12 <= n_off12;
            r_idx12 <= n_idx12;
        end
    end

endmodule

@@ src/urp_outq.sv @@
// Four-entry result queue; takes up to two records per cycle, emits one while the output is ready.
module urp_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  urp_pkg::t_push      i_push,
    output logic                o_valid,
    input  logic                i_ready,
    output urp_pkg::t_out_item  o_item,
    output urp_pkg::t_q_status  o_status
);
    import urp_pkg::*;

    t_out_item  r_mem [4];
    logic [1:0] r_wp, n_wp;
    logic [1:0] r_rp, n_rp;
    logic [2:0] r_cnt, n_cnt;
    logic       w_pop;

    assign o_valid = r_cnt != 3'd0;
    assign o_item  = r_mem[r_rp];
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_wp  = r_wp + i_push.count;
        n_rp  = r_rp + {1'b0, w_pop};
        n_cnt = r_cnt + {1'b0, i_push.count} - {2'd0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0)
            r_mem[r_wp] <= i_push.first;
        if (i_push.count == 2'd2)
            r_mem[r_wp + 2'd1] <= i_push.second;
    end

    // room for the worst case of two records from the next byte
    assign o_status.count = r_cnt;
    assign o_status.room  = r_cnt <= 3'd2;

endmodule

@@ bench/udp_tracker_response_parser_test.sv @@
// Self-checking testbench for the UDP tracker response parser.
`timescale 1ns / 1ps

module udp_tracker_response_parser_test;
    import urp_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_BYTES  = 240;
    localparam int MAX_GAP       = 20;
    localparam int MAX_REPORTS   = 10;
    localparam int ACTION_BYTES  = 4;
    localparam int ANN_LEECH_POS = 12;
    localparam int ANN_SEED_POS  = 16;
    localparam int PEER_BYTES    = 6;
    localparam int SCRAPE_BYTES  = 12;
    localparam logic [1:0] KIND_NONE = 2'd3;   // not a valid response kind

    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;
    localparam int STATUS_PREDICT = -1;

    typedef struct {
        logic [1:0]  kind;
        logic [6:0]  hashes;
        logic [31:0] action;
        int          len;
        int          fill;
        int          status;
    } t_row;

    t_row directed_rows [21] = '{
        '{KIND_CONNECT,  7'd1,   32'(KIND_CONNECT),  16,    FILL_RANDOM, REC_DONE_OK},
        '{KIND_CONNECT,  7'd1,   32'(KIND_CONNECT),  15,    FILL_RANDOM, REC_DONE_FAIL},
        '{KIND_CONNECT,  7'd1,   32'(KIND_CONNECT),  24,    FILL_ONES,   STATUS_PREDICT},
        '{KIND_CONNECT,  7'd1,   ACTION_ERROR,       16,    FILL_RANDOM, REC_DONE_FAIL},
        '{KIND_CONNECT,  7'd1,   32'(KIND_ANNOUNCE), 16,    FILL_ZERO,   REC_DONE_FAIL},
        '{KIND_CONNECT,  7'd1,   32'(KIND_CONNECT),  1,     FILL_RANDOM, REC_DONE_FAIL},
        '{KIND_ANNOUNCE, 7'd1,   32'(KIND_ANNOUNCE), 20,    FILL_RANDOM, REC_DONE_OK},
        '{KIND_ANNOUNCE, 7'd1,   32'(KIND_ANNOUNCE), 19,    FILL_RANDOM, REC_DONE_FAIL},
        '{KIND_ANNOUNCE, 7'd1,   32'(KIND_ANNOUNCE), 83,    FILL_RANDOM, STATUS_PREDICT},
        '{KIND_ANNOUNCE, 7'd1,   32'(KIND_ANNOUNCE), 38,    FILL_ZERO,   STATUS_PREDICT},
        '{KIND_ANNOUNCE, 7'd1,   32'(KIND_ANNOUNCE), 38,    FILL_ONES,   STATUS_PREDICT},
        '{KIND_ANNOUNCE, 7'd1,   32'hFFFF_FFFF,      26,    FILL_RANDOM, REC_DONE_FAIL},
        '{KIND_ANNOUNCE, 7'd1,   ACTION_ERROR,       8,     FILL_RANDOM, REC_DONE_FAIL},
        '{KIND_SCRAPE,   7'd1,   32'(KIND_SCRAPE),   20,    FILL_RANDOM, REC_DONE_OK},
        '{KIND_SCRAPE,   7'd1,   32'(KIND_SCRAPE),   19,    FILL_RANDOM, REC_DONE_FAIL},
        '{KIND_SCRAPE,   7'd0,   32'(KIND_SCRAPE),   8,     FILL_RANDOM, REC_DONE_OK},
        '{KIND_SCRAPE,   7'd5,   32'(KIND_SCRAPE),   80,    FILL_ONES,   STATUS_PREDICT},
        '{KIND_SCRAPE,   7'd64,  32'(KIND_SCRAPE),   32,    FILL_RANDOM, STATUS_PREDICT},
        '{KIND_SCRAPE,   7'd127, 32'(KIND_SCRAPE),   20,    FILL_RANDOM, STATUS_PREDICT},
        '{KIND_NONE,     7'd1,   32'(KIND_CONNECT),  16,    FILL_RANDOM, REC_DONE_FAIL},
        '{KIND_NONE,     7'd1,   ACTION_ERROR,       2,     FILL_RANDOM, REC_DONE_FAIL}
    };

    int phase_idle  [4] = '{0, 57, 0, 12};
    int phase_stall [4] = '{0, 0, 57, 12};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // shadow registers and packet state of the parser model
    logic [1:0]  kind_reg = KIND_CONNECT;
    logic [6:0]  hash_reg = 7'd1;
    logic [15:0] byte_cnt = '0;
    logic [31:0] act_word = '0;
    logic [63:0] acc_a = '0;
    logic [31:0] acc_b = '0;
    logic [31:0] acc_c = '0;
    logic        act_bad = 1'b0;
    logic [13:0] slots = '0;

    t_out_item   expected_records [$];
    int          status_plan [$];
    logic [7:0]  packet_bytes [$];

    int idle_pct = 0;
    int stall_pct = 0;
    int mismatch_count = 0;
    int bytes_accepted = 0;
    int cycle_count = 0;

    udp_tracker_response_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("udp_tracker_response_parser test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic push_record(input logic [2:0] kind, input logic [63:0] a,
                               input logic [31:0] b, input logic [31:0] c,
                               input logic [13:0] idx, input logic eop);
        t_out_item rec;
        rec.record_kind   = kind;
        rec.field_a       = a;
        rec.field_b       = b;
        rec.field_c       = c;
        rec.entry_index   = idx;
        rec.end_of_packet = eop;
        expected_records.push_back(rec);
    endtask

    // Advance the parser model by one byte and queue the records it yields.
    task automatic parse_byte(input t_in_item item);
        int unsigned pos, off, rel, slot, hashes, need;
        logic        ok;
        int          typed;
        pos = byte_cnt;
        hashes = (hash_reg > MAX_HASHES) ? MAX_HASHES : hash_reg;
        if (byte_cnt != COUNT_MAX) begin
            if (pos < ACTION_BYTES) begin
                act_word = {act_word[23:0], item.data_byte};
                if (pos == ACTION_BYTES - 1 && (kind_reg > KIND_SCRAPE ||
                        act_word == ACTION_ERROR || act_word != {30'd0, kind_reg}))
                    act_bad = 1'b1;
            end else if (pos >= LEN_SCRAPE_HD && !act_bad) begin
                case (kind_reg)
                    KIND_CONNECT: begin
                        if (pos < LEN_CONNECT) begin
                            acc_a = {acc_a[55:0], item.data_byte};
                            if (pos == LEN_CONNECT - 1)
                                push_record(REC_CONN_ID, acc_a, '0, '0, '0, 1'b0);
                        end
                    end
                    KIND_ANNOUNCE: begin
                        if (pos < ANN_LEECH_POS) begin
                            acc_a = {acc_a[55:0], item.data_byte};
                        end else if (pos < ANN_SEED_POS) begin
                            acc_b = {acc_b[23:0], item.data_byte};
                        end else if (pos < LEN_ANNOUNCE) begin
                            acc_c = {acc_c[23:0], item.data_byte};
                            if (pos == LEN_ANNOUNCE - 1)
                                push_record(REC_ANNOUNCE, {32'd0, acc_a[31:0]}, acc_b, acc_c,
                                            '0, 1'b0);
                        end else begin
                            off = (pos - LEN_ANNOUNCE) % PEER_BYTES;
                            if (off < 4)
                                acc_a = {acc_a[55:0], item.data_byte};
                            else
                                acc_b = {acc_b[23:0], item.data_byte};
                            if (off == PEER_BYTES - 1) begin
                                // skipped peers still use up a slot
                                if (acc_a[31:0] != 0 && acc_b[15:0] != 0 &&
                                        acc_b[15:0] <= PEER_PORT_MAX)
                                    push_record(REC_PEER, {32'd0, acc_a[31:0]},
                                                {16'd0, acc_b[15:0]}, '0, slots, 1'b0);
                                slots = slots + 14'd1;
                            end
                        end
                    end
                    KIND_SCRAPE: begin
                        rel  = pos - LEN_SCRAPE_HD;
                        slot = rel / SCRAPE_BYTES;
                        off  = rel % SCRAPE_BYTES;
                        if (slot < hashes) begin
                            if (off < 4)
                                acc_a = {acc_a[55:0], item.data_byte};
                            else if (off < 8)
                                acc_b = {acc_b[23:0], item.data_byte};
                            else
                                acc_c = {acc_c[23:0], item.data_byte};
                            if (off == SCRAPE_BYTES - 1) begin
                                push_record(REC_SCRAPE, {32'd0, acc_a[31:0]}, acc_b, acc_c,
                                            14'(slot), 1'b0);
                                slots = 14'(slot + 1);
                            end
                        end
                    end
                    default: ;
                endcase
            end
            byte_cnt = byte_cnt + 16'd1;
        end
        if (item.last_byte) begin
            case (kind_reg)
                KIND_CONNECT:  need = LEN_CONNECT;
                KIND_ANNOUNCE: need = LEN_ANNOUNCE;
                default:       need = LEN_SCRAPE_HD + SCRAPE_BYTES * hashes;
            endcase
            ok = !act_bad && kind_reg <= KIND_SCRAPE && byte_cnt >= need;
            typed = status_plan.pop_front();
            push_record((typed >= 0) ? 3'(typed) : (ok ? REC_DONE_OK : REC_DONE_FAIL),
                        '0, '0, '0, '0, 1'b1);
            byte_cnt = '0;
            act_word = '0;
            acc_a    = '0;
            acc_b    = '0;
            acc_c    = '0;
            act_bad  = 1'b0;
            slots    = '0;
        end
    endtask

    // input transfers feed the model first, so a same-edge record finds its expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                parse_byte(i_in_data);
                bytes_accepted++;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_records.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected record: kind %0d a %h b %h c %h index %0d eop %b",
                                 o_out_data.record_kind, o_out_data.field_a,
                                 o_out_data.field_b, o_out_data.field_c,
                                 o_out_data.entry_index, o_out_data.end_of_packet);
                end else begin
                    want = expected_records.pop_front();
                    if (o_out_data.record_kind !== want.record_kind ||
                            o_out_data.field_a !== want.field_a ||
                            o_out_data.field_b !== want.field_b ||
                            o_out_data.field_c !== want.field_c ||
                            o_out_data.entry_index !== want.entry_index ||
                            o_out_data.end_of_packet !== want.end_of_packet) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("record mismatch: expected kind %0d a %h b %h c %h ",
                                     want.record_kind, want.field_a, want.field_b,
                                     want.field_c, "index %0d eop %b; got kind %0d a %h ",
                                     want.entry_index, want.end_of_packet,
                                     o_out_data.record_kind, o_out_data.field_a,
                                     "b %h c %h index %0d eop %b", o_out_data.field_b,
                                     o_out_data.field_c, o_out_data.entry_index,
                                     o_out_data.end_of_packet);
                    end
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] data, input logic last);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{data_byte: data, last_byte: last};
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // stop sending and hold off until every expected record has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_records.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_EXPECTED_KIND)
            kind_reg = value[1:0];
        else
            hash_reg = value[6:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [1:0] kind, input logic [6:0] hashes);
        drain_results();
        reg_write(REG_EXPECTED_KIND, {30'd0, kind});
        reg_write(REG_HASH_COUNT, {25'd0, hashes});
    endtask

    task automatic build_packet(input logic [31:0] action, input int len, input int fill);
        int          off;
        logic [31:0] peer_ip;
        logic [15:0] peer_port;
        logic [7:0]  b;
        packet_bytes.delete();
        peer_ip   = '0;
        peer_port = '0;
        for (int i = 0; i < len; i++) begin
            if (i < ACTION_BYTES) begin
                b = action[31 - 8 * i -: 8];
            end else if (fill == FILL_ZERO) begin
                b = 8'h00;
            end else if (fill == FILL_ONES) begin
                b = 8'hFF;
            end else if (i < LEN_ANNOUNCE) begin
                b = 8'($urandom_range(255));
            end else begin
                // peer-shaped body: valid peers mixed with zero address, zero port and ports at and past the limit
                off = (i - LEN_ANNOUNCE) % PEER_BYTES;
                if (off == 0) begin
                    peer_ip = $urandom;
                    case ($urandom_range(9))
                        0: begin
                            peer_ip   = '0;
                            peer_port = 16'($urandom);
                        end
                        1: peer_port = '0;
                        2: peer_port = 16'($urandom_range(65001, 65535));
                        3: peer_port = $urandom_range(1) ? PEER_PORT_MAX
                                                         : PEER_PORT_MAX + 16'd1;
                        default: peer_port = 16'($urandom_range(1, 65000));
                    endcase
                end
                b = (off < 4) ? peer_ip[31 - 8 * off -: 8] : peer_port[15 - 8 * (off - 4) -: 8];
            end
            packet_bytes.push_back(b);
        end
    endtask

    task automatic send_packet(input int status);
        status_plan.push_back(status);
        foreach (packet_bytes[i])
            send_byte(packet_bytes[i], i == packet_bytes.size() - 1);
    endtask

    task automatic random_config();
        logic [1:0] kind;
        logic [6:0] hashes;
        kind = ($urandom_range(9) == 0) ? KIND_NONE : 2'($urandom_range(2));
        case ($urandom_range(19))
            0: hashes = 7'($urandom_range(65, 127));
            1: hashes = MAX_HASHES;
            2: hashes = 7'd0;
            default: hashes = 7'($urandom_range(1, 4));
        endcase
        set_config(kind, hashes);
    endtask

    // mostly well-formed responses for the current setting, some broken
    task automatic random_packet();
        logic [31:0] action;
        int          len;
        int          hashes;
        hashes = (hash_reg > MAX_HASHES) ? MAX_HASHES : hash_reg;
        action = {30'd0, kind_reg};
        case (kind_reg)
            KIND_CONNECT:  len = LEN_CONNECT + $urandom_range(4);
            KIND_ANNOUNCE: len = LEN_ANNOUNCE + PEER_BYTES * $urandom_range(6) +
                                 (($urandom_range(3) == 0) ? $urandom_range(1, 5) : 0);
            KIND_SCRAPE:   len = LEN_SCRAPE_HD + $urandom_range(2) +
                                 SCRAPE_BYTES * ((hashes <= 4) ? hashes : $urandom_range(3));
            default:       len = $urandom_range(1, 24);
        endcase
        if ($urandom_range(4) == 0) begin
            case ($urandom_range(3))
                0: action = $urandom;
                1: action = ACTION_ERROR;
                2: action = {30'd0, 2'($urandom_range(2))};
                default: len = $urandom_range(1, len);
            endcase
        end
        build_packet(action, len, FILL_RANDOM);
        send_packet(STATUS_PREDICT);
    endtask

    initial begin
        int stop_at;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first rows run on the reset setting
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind != kind_reg || directed_rows[r].hashes != hash_reg)
                set_config(directed_rows[r].kind, directed_rows[r].hashes);
            build_packet(directed_rows[r].action, directed_rows[r].len, directed_rows[r].fill);
            send_packet(directed_rows[r].status);
        end

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = phase_idle[ph];
            stall_pct = phase_stall[ph];
            random_config();
            stop_at = bytes_accepted + RANDOM_BYTES / 4;
            while (bytes_accepted < stop_at) begin
                if ($urandom_range(3) == 0)
                    random_config();
                random_packet();
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_records.size() == 0) begin
            $display("udp_tracker_response_parser test passed");
        end else begin
            $display("udp_tracker_response_parser test failed");
        end
        $finish;
    end

endmodule
